/* rtl/assert_macros.svh */
// Assertion shorthands used by the checker file ggpa_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising aclk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every rising aclk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

/* rtl/ggpa_pkg.sv */
package ggpa_pkg;

    localparam int COORD_W           = 16;
    localparam int GATE_W            = 33;
    localparam int SQ_W              = 32;
    localparam int MAX_LANDMARKS_DEF = 16;
    localparam int MAX_CENTROIDS_DEF = 64;

    // (0.2 m)^2 in (1/1024 m)^2 units, truncated
    localparam logic [GATE_W-1:0] GATE_RESET = 33'd41943;

    localparam logic [1:0] OP_CLEAR       = 2'd0;
    localparam logic [1:0] OP_APPEND_LM   = 2'd1;
    localparam logic [1:0] OP_APPEND_CENT = 2'd2;
    localparam logic [1:0] OP_RUN         = 2'd3;

    // y in the high half, x in the low half
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
    } in_item_t;

    typedef struct packed {
        logic [3:0] landmark_index;
        logic       matched;
        logic [5:0] centroid_index;
        logic       last_result;
    } out_item_t;

    typedef struct packed {
        logic   used;
        point_t pt;
    } cell_data_t;

    typedef struct packed {
        logic shift_en;
        logic load_en;
        logic clr_used;
        logic set_used;
    } cell_ctrl_t;

    typedef struct packed {
        logic valid;
        logic cand;
    } dist_tag_t;

endpackage

/* rtl/gated_greedy_point_association.sv */
// Greedy gated nearest-neighbor association of landmarks to centroids.
// Input channel s_valid/s_ready/s_data carries commands: clear both lists,
// append a landmark, append a centroid, or run matching. Clear and appends
// give no result; appends to a full list are dropped. A run gives one item
// per loaded landmark on m_valid/m_ready/m_data, in load order, the final
// one flagged last_result. Each landmark goes through a landmark memory
// read, a pass over every ring position as the centroid ring rotates past
// the shared three-stage distance pipeline, and the pipeline drain. s_ready
// stays low for the whole run.
// Results go through an output register, so a stalled receiver holds the
// run at the next result; once the run ends, commands are taken again even
// while the last result waits. cfg_wr_en/cfg_wr_data write the squared gate
// at any edge; it is sampled at the start of each landmark.
// Reset empties both lists, clears the used flags and restores the gate.
module gated_greedy_point_association #(
    parameter int MAX_LANDMARKS = ggpa_pkg::MAX_LANDMARKS_DEF,
    parameter int MAX_CENTROIDS = ggpa_pkg::MAX_CENTROIDS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ggpa_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ggpa_pkg::out_item_t          m_data,
    input  logic                         cfg_wr_en,
    input  logic [ggpa_pkg::GATE_W-1:0]  cfg_wr_data
);

    localparam int LIDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int CIDX_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int LCNT_W = $clog2(MAX_LANDMARKS + 1);
    localparam int CCNT_W = $clog2(MAX_CENTROIDS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOAD   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [LIDX_W-1:0]           li_reg;
    logic [CIDX_W-1:0]           scan_idx_reg;
    logic [LCNT_W-1:0]           lm_count_reg;
    logic [CCNT_W-1:0]           cent_count_reg;
    logic [ggpa_pkg::GATE_W-1:0] gate_reg;
    logic [ggpa_pkg::GATE_W-1:0] best_dist_reg;
    logic [CIDX_W-1:0]           best_idx_reg;
    logic                        found_reg;
    logic                        m_valid_reg;
    ggpa_pkg::out_item_t         m_data_reg;

    ggpa_pkg::point_t            lm_mem [MAX_LANDMARKS];
    ggpa_pkg::point_t            lm_rd_reg;
    ggpa_pkg::point_t            app_pt;
    ggpa_pkg::cell_data_t        ring [MAX_CENTROIDS];

    ggpa_pkg::dist_tag_t         feed_tag, dist_tag;
    logic [CIDX_W-1:0]           dist_idx;
    logic [ggpa_pkg::GATE_W-1:0] dist_val;
    logic                        dist_busy;

    logic s_acc, do_clear, do_run, app_lm, app_cent;
    logic scan_last, last_lm, out_free, emit, mark, hit;
    logic [CIDX_W+5:0]           cidx_ext;
    logic [LIDX_W+3:0]           lidx_ext;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid & s_ready;
    assign do_clear = s_acc && (s_data.opcode == ggpa_pkg::OP_CLEAR);
    assign do_run   = s_acc && (s_data.opcode == ggpa_pkg::OP_RUN);
    assign app_lm   = s_acc && (s_data.opcode == ggpa_pkg::OP_APPEND_LM)
                    && (lm_count_reg != LCNT_W'(MAX_LANDMARKS));
    assign app_cent = s_acc && (s_data.opcode == ggpa_pkg::OP_APPEND_CENT)
                    && (cent_count_reg != CCNT_W'(MAX_CENTROIDS));

    assign app_pt.x = s_data.coord_x;
    assign app_pt.y = s_data.coord_y;

    assign scan_last = (scan_idx_reg == CIDX_W'(MAX_CENTROIDS - 1));
    assign last_lm   = ((LCNT_W'(li_reg) + LCNT_W'(1)) == lm_count_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = (state_reg == ST_FINISH) && !dist_busy && out_free;
    assign mark      = emit && found_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (do_run && (lm_count_reg != '0)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (emit) begin
                    state_next = last_lm ? ST_IDLE : ST_LOAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            li_reg         <= '0;
            scan_idx_reg   <= '0;
            lm_count_reg   <= '0;
            cent_count_reg <= '0;
            gate_reg       <= ggpa_pkg::GATE_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                gate_reg <= cfg_wr_data;
            end
            if (do_clear) begin
                lm_count_reg   <= '0;
                cent_count_reg <= '0;
            end else begin
                if (app_lm) begin
                    lm_count_reg <= lm_count_reg + LCNT_W'(1);
                end
                if (app_cent) begin
                    cent_count_reg <= cent_count_reg + CCNT_W'(1);
                end
            end
            if (do_run) begin
                li_reg <= '0;
            end else if (emit && !last_lm) begin
                li_reg <= li_reg + LIDX_W'(1);
            end
            // wraps so the ring is back in index order after every landmark
            if (state_reg == ST_SCAN) begin
                scan_idx_reg <= scan_last ? '0 : scan_idx_reg + CIDX_W'(1);
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (app_lm) begin
            lm_mem[lm_count_reg[LIDX_W-1:0]] <= app_pt;
        end
        lm_rd_reg <= lm_mem[li_reg];
    end

    // centroid 0 sits at the head of the ring while scan index 0 is fed
    assign feed_tag.valid = (state_reg == ST_SCAN);
    assign feed_tag.cand  = (CCNT_W'(scan_idx_reg) < cent_count_reg) && !ring[0].used;

    ggpa_dist #(
        .IDX_W (CIDX_W)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lm_pt    (lm_rd_reg),
        .c_pt     (ring[0].pt),
        .in_tag   (feed_tag),
        .in_idx   (scan_idx_reg),
        .out_tag  (dist_tag),
        .out_idx  (dist_idx),
        .out_dist (dist_val),
        .busy     (dist_busy)
    );

    // strict compare keeps the earliest centroid on a tie
    assign hit = dist_tag.valid && dist_tag.cand && (dist_val < best_dist_reg);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD) begin
            best_dist_reg <= gate_reg;
            best_idx_reg  <= '0;
            found_reg     <= 1'b0;
        end else if (hit) begin
            best_dist_reg <= dist_val;
            best_idx_reg  <= dist_idx;
            found_reg     <= 1'b1;
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_CENTROIDS; k++) begin : g_ring
            localparam int NXT = (k == MAX_CENTROIDS - 1) ? 0 : k + 1;
            ggpa_pkg::cell_ctrl_t ctrl;

            assign ctrl.shift_en = (state_reg == ST_SCAN);
            assign ctrl.load_en  = app_cent && (cent_count_reg == CCNT_W'(k));
            assign ctrl.clr_used = do_clear || do_run;
            assign ctrl.set_used = mark && (best_idx_reg == CIDX_W'(k));

            ggpa_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .load_pt  (app_pt),
                .shift_in (ring[NXT]),
                .cell_out (ring[k])
            );
        end
    endgenerate

    assign cidx_ext = {6'd0, best_idx_reg};
    assign lidx_ext = {4'd0, li_reg};

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg.landmark_index <= lidx_ext[3:0];
            m_data_reg.matched        <= found_reg;
            m_data_reg.centroid_index <= found_reg ? cidx_ext[5:0] : 6'd0;
            m_data_reg.last_result    <= last_lm;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/ggpa_cell.sv */
// One centroid slot of the rotating ring.
module ggpa_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ggpa_pkg::cell_ctrl_t  ctrl,
    input  ggpa_pkg::point_t      load_pt,
    input  ggpa_pkg::cell_data_t  shift_in,
    output ggpa_pkg::cell_data_t  cell_out
);

    ggpa_pkg::point_t pt_reg;
    logic             used_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            pt_reg <= shift_in.pt;
        end else if (ctrl.load_en) begin
            pt_reg <= load_pt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (ctrl.clr_used) begin
            used_reg <= 1'b0;
        end else if (ctrl.shift_en) begin
            used_reg <= shift_in.used;
        end else if (ctrl.set_used) begin
            used_reg <= 1'b1;
        end
    end

    assign cell_out.used = used_reg;
    assign cell_out.pt   = pt_reg;

endmodule

/* rtl/ggpa_dist.sv */
// Three-stage squared distance: difference, square, sum.
module ggpa_dist #(
    parameter int IDX_W = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ggpa_pkg::point_t             lm_pt,
    input  ggpa_pkg::point_t             c_pt,
    input  ggpa_pkg::dist_tag_t          in_tag,
    input  logic [IDX_W-1:0]             in_idx,
    output ggpa_pkg::dist_tag_t          out_tag,
    output logic [IDX_W-1:0]             out_idx,
    output logic [ggpa_pkg::GATE_W-1:0]  out_dist,
    output logic                         busy
);

    logic signed [ggpa_pkg::COORD_W:0]     dx_reg, dy_reg;
    logic signed [2*ggpa_pkg::COORD_W+1:0] prod_x, prod_y;
    logic [ggpa_pkg::SQ_W-1:0]             sqx_reg, sqy_reg;
    logic [ggpa_pkg::GATE_W-1:0]           dist_reg;
    ggpa_pkg::dist_tag_t                   t1_reg, t2_reg, t3_reg;
    logic [IDX_W-1:0]                      i1_reg, i2_reg, i3_reg;

    // |d| <= 65535, so the square fits in 32 bits
    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;

    always_ff @(posedge aclk) begin
        dx_reg   <= {lm_pt.x[ggpa_pkg::COORD_W-1], lm_pt.x}
                  - {c_pt.x[ggpa_pkg::COORD_W-1], c_pt.x};
        dy_reg   <= {lm_pt.y[ggpa_pkg::COORD_W-1], lm_pt.y}
                  - {c_pt.y[ggpa_pkg::COORD_W-1], c_pt.y};
        sqx_reg  <= prod_x[ggpa_pkg::SQ_W-1:0];
        sqy_reg  <= prod_y[ggpa_pkg::SQ_W-1:0];
        dist_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        i1_reg   <= in_idx;
        i2_reg   <= i1_reg;
        i3_reg   <= i2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
        end else begin
            t1_reg <= in_tag;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
        end
    end

    assign out_tag  = t3_reg;
    assign out_idx  = i3_reg;
    assign out_dist = dist_reg;
    assign busy     = t1_reg.valid | t2_reg.valid | t3_reg.valid;

endmodule

/* rtl/ggpa_checker.sv */
`include "assert_macros.svh"

module ggpa_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input ggpa_pkg::in_item_t   s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input ggpa_pkg::out_item_t  m_data
);

    `ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")

    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled item changed")

    // a non-final result means the run is still going
    `ASSERT_CLK(a_busy_mid_run, m_valid && !m_data.last_result |-> !s_ready, "input taken mid-run")

    `ASSERT_CLK(a_unmatched_zero, m_valid && !m_data.matched |-> m_data.centroid_index == 6'd0, "unmatched item has nonzero centroid index")

    `ASSERT_CLK(a_stall_after_run, $fell(s_ready) |-> $past(s_valid && s_data.opcode == ggpa_pkg::OP_RUN), "input stalled without a run")

endmodule

bind gated_greedy_point_association ggpa_checker u_ggpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
